[design/bhpq_pkg.sv]
// Shared package of the binary heap priority queue: default sizes, result status
// codes, the controller command code and the datapath status bundle.
// Depends on nothing; all design files but bhpq_ram refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int TAG_BITS_DEFAULT = 16;

   localparam int STATUS_BITS = 2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   // Command the controller issues to the datapath each cycle.
   typedef enum logic [3:0] {
      CMD_NONE         = 4'd0,
      CMD_PUSH_START   = 4'd1,
      CMD_POP_START    = 4'd2,
      CMD_REJECT_FULL  = 4'd3,
      CMD_REJECT_EMPTY = 4'd4,
      CMD_PUSH_CHECK   = 4'd5,
      CMD_PUSH_COMPARE = 4'd6,
      CMD_POP_LAST     = 4'd7,
      CMD_POP_CHECK    = 4'd8,
      CMD_POP_LEFT     = 4'd9,
      CMD_POP_DECIDE   = 4'd10,
      CMD_PUBLISH      = 4'd11
   } cmd_type;

   // Status the datapath reports back to the controller.
   typedef struct packed {
      logic full;      // store holds CAPACITY entries
      logic empty;     // store holds no entry
      logic pos_root;  // the hole sits at the root slot
      logic climb;     // moving entry is strictly better than the entry just read
      logic left_in;   // left child of the hole lies inside the heap
      logic settle;    // sift-down found no child that takes the hole
   } dp_status_type;

endpackage

`default_nettype wire

[design/bhpq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/bhpq_datapath.sv]
// Datapath of the heap: entry store, moving entry, hole position, count, root mirror,
// comparator and result registers. It acts on one command per cycle.
// Depends on bhpq_pkg and bhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_datapath #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEFAULT,
   parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEFAULT,
   localparam int AddrW = $clog2(CAPACITY),
   localparam int CntW  = $clog2(CAPACITY + 1),
   localparam int EntW  = KEY_BITS + TAG_BITS,
   localparam int IdxW  = AddrW + 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bhpq_pkg::cmd_type                cmd,
   output bhpq_pkg::dp_status_type               status,
   input  wire logic                             csr_wr_en,
   input  wire logic                             csr_wr_data,
   input  wire logic [KEY_BITS-1:0]              in_key,
   input  wire logic [TAG_BITS-1:0]              in_tag,
   output logic      [KEY_BITS-1:0]              popped_key,
   output logic      [TAG_BITS-1:0]              popped_tag,
   output logic      [KEY_BITS-1:0]              front_key,
   output logic      [TAG_BITS-1:0]              front_tag,
   output logic      [CntW-1:0]                  entry_count,
   output logic      [bhpq_pkg::STATUS_BITS-1:0] result_status
);

   // Control state.
   logic            order_mode_ff;
   logic            order_mode_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   // Working registers.
   logic [AddrW-1:0] pos_ff, pos_in;
   logic [EntW-1:0]  cur_ff, cur_in;
   logic [EntW-1:0]  best_ff, best_in;
   logic             best_is_cur_ff, best_is_cur_in;
   logic [AddrW-1:0] best_idx_ff, best_idx_in;
   logic             right_in_ff, right_in_in;
   logic [EntW-1:0]  front_ff, front_in;
   logic [EntW-1:0]  popped_ff, popped_in;
   logic [bhpq_pkg::STATUS_BITS-1:0] op_status_ff, op_status_in;

   // Result registers.
   logic [EntW-1:0] rsp_popped_ff, rsp_popped_in;
   logic [EntW-1:0] rsp_front_ff, rsp_front_in;
   logic [CntW-1:0] rsp_count_ff, rsp_count_in;
   logic [bhpq_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   // Store port.
   logic             wr_en;
   logic [EntW-1:0]  wr_data;
   logic [AddrW-1:0] rd_addr;
   logic [EntW-1:0]  rd_data;

   logic [IdxW-1:0]  left_idx;
   logic [IdxW-1:0]  right_idx;
   logic [IdxW-1:0]  count_ext;
   logic [AddrW-1:0] parent_idx;
   logic [CntW-1:0]  count_dec;
   logic             climb;
   logic             use_right;
   logic             settle;

   function automatic logic better(input logic mode, input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
      return mode ? (a > b) : (a < b);
   endfunction

   assign left_idx   = IdxW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + IdxW'(1);
   assign count_ext  = IdxW'(count_ff);
   assign parent_idx = (pos_ff - AddrW'(1)) >> 1;
   assign count_dec  = count_ff - CntW'(1);

   // The entry just read is the parent on a push and the left child on a pop.
   assign climb     = better(order_mode_ff, cur_ff[KEY_BITS-1:0], rd_data[KEY_BITS-1:0]);
   assign use_right = right_in_ff &&
                      !better(order_mode_ff, best_ff[KEY_BITS-1:0], rd_data[KEY_BITS-1:0]);
   assign settle    = !use_right && best_is_cur_ff;

   assign status.full     = (count_ff == CntW'(CAPACITY));
   assign status.empty    = (count_ff == '0);
   assign status.pos_root = (pos_ff == '0);
   assign status.climb    = climb;
   assign status.left_in  = (left_idx < count_ext);
   assign status.settle   = settle;

   always_comb begin
      order_mode_in  = csr_wr_en ? csr_wr_data : order_mode_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      best_in        = best_ff;
      best_is_cur_in = best_is_cur_ff;
      best_idx_in    = best_idx_ff;
      right_in_in    = right_in_ff;
      popped_in      = popped_ff;
      op_status_in   = op_status_ff;
      rsp_popped_in  = rsp_popped_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_data        = cur_ff;

      unique case (cmd)
         bhpq_pkg::CMD_NONE: begin
         end
         bhpq_pkg::CMD_PUSH_START: begin
            cur_in       = {in_tag, in_key};
            pos_in       = count_ff[AddrW-1:0];
            count_in     = count_ff + CntW'(1);
            popped_in    = '0;
            op_status_in = bhpq_pkg::STATUS_OK;
         end
         bhpq_pkg::CMD_POP_START: begin
            popped_in    = front_ff;
            count_in     = count_dec;
            op_status_in = bhpq_pkg::STATUS_OK;
            rd_addr      = count_dec[AddrW-1:0];
         end
         bhpq_pkg::CMD_REJECT_FULL: begin
            popped_in    = '0;
            op_status_in = bhpq_pkg::STATUS_FULL;
         end
         bhpq_pkg::CMD_REJECT_EMPTY: begin
            popped_in    = '0;
            op_status_in = bhpq_pkg::STATUS_EMPTY;
         end
         bhpq_pkg::CMD_PUSH_CHECK: begin
            rd_addr = parent_idx;
            wr_en   = (pos_ff == '0);
         end
         bhpq_pkg::CMD_PUSH_COMPARE: begin
            // The parent moves down into the hole, or the new entry lands there.
            wr_en   = 1'b1;
            wr_data = climb ? rd_data : cur_ff;
            if (climb) begin
               pos_in = parent_idx;
            end
         end
         bhpq_pkg::CMD_POP_LAST: begin
            cur_in = rd_data;
            pos_in = '0;
         end
         bhpq_pkg::CMD_POP_CHECK: begin
            rd_addr = left_idx[AddrW-1:0];
            wr_en   = !(left_idx < count_ext);
         end
         bhpq_pkg::CMD_POP_LEFT: begin
            // On equal keys the child wins, so the moving entry goes down.
            rd_addr        = right_idx[AddrW-1:0];
            best_in        = climb ? cur_ff : rd_data;
            best_is_cur_in = climb;
            best_idx_in    = left_idx[AddrW-1:0];
            right_in_in    = (right_idx < count_ext);
         end
         bhpq_pkg::CMD_POP_DECIDE: begin
            wr_en   = 1'b1;
            wr_data = use_right ? rd_data : best_ff;
            pos_in  = use_right ? right_idx[AddrW-1:0] : best_idx_ff;
         end
         bhpq_pkg::CMD_PUBLISH: begin
            rsp_popped_in = popped_ff;
            rsp_front_in  = (count_ff == '0) ? '0 : front_ff;
            rsp_count_in  = count_ff;
            rsp_status_in = op_status_ff;
         end
         default: begin
         end
      endcase
   end

   // Slot zero is mirrored so the front and a popped root need no read.
   assign front_in = (wr_en && pos_ff == '0) ? wr_data : front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         order_mode_ff <= order_mode_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      best_ff        <= best_in;
      best_is_cur_ff <= best_is_cur_in;
      best_idx_ff    <= best_idx_in;
      right_in_ff    <= right_in_in;
      front_ff       <= front_in;
      popped_ff      <= popped_in;
      op_status_ff   <= op_status_in;
      rsp_popped_ff  <= rsp_popped_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   bhpq_ram #(
      .WIDTH(EntW),
      .DEPTH(CAPACITY)
   ) u_bhpq_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign popped_key    = rsp_popped_ff[KEY_BITS-1:0];
   assign popped_tag    = rsp_popped_ff[EntW-1:KEY_BITS];
   assign front_key     = rsp_front_ff[KEY_BITS-1:0];
   assign front_tag     = rsp_front_ff[EntW-1:KEY_BITS];
   assign entry_count   = rsp_count_ff;
   assign result_status = rsp_status_ff;

endmodule

`default_nettype wire

[design/bhpq_ctrl.sv]
// Controller of the heap: one-hot state machine that sequences push and pop sifts,
// drives the datapath command and owns the handshakes.
// Depends on bhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_action,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire bhpq_pkg::dp_status_type status,
   output bhpq_pkg::cmd_type            cmd
);

   typedef enum logic [7:0] {
      S_IDLE         = 8'b0000_0001,
      S_PUSH_CHECK   = 8'b0000_0010,
      S_PUSH_COMPARE = 8'b0000_0100,
      S_POP_LAST     = 8'b0000_1000,
      S_POP_CHECK    = 8'b0001_0000,
      S_POP_LEFT     = 8'b0010_0000,
      S_POP_DECIDE   = 8'b0100_0000,
      S_DONE         = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = bhpq_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == bhpq_pkg::ACTION_PUSH) begin
                  cmd      = status.full ? bhpq_pkg::CMD_REJECT_FULL
                                         : bhpq_pkg::CMD_PUSH_START;
                  state_in = status.full ? S_DONE : S_PUSH_CHECK;
               end else begin
                  cmd      = status.empty ? bhpq_pkg::CMD_REJECT_EMPTY
                                          : bhpq_pkg::CMD_POP_START;
                  state_in = status.empty ? S_DONE : S_POP_LAST;
               end
            end
         end
         S_PUSH_CHECK: begin
            cmd      = bhpq_pkg::CMD_PUSH_CHECK;
            state_in = status.pos_root ? S_DONE : S_PUSH_COMPARE;
         end
         S_PUSH_COMPARE: begin
            cmd      = bhpq_pkg::CMD_PUSH_COMPARE;
            state_in = status.climb ? S_PUSH_CHECK : S_DONE;
         end
         S_POP_LAST: begin
            cmd      = bhpq_pkg::CMD_POP_LAST;
            state_in = status.empty ? S_DONE : S_POP_CHECK;
         end
         S_POP_CHECK: begin
            cmd      = bhpq_pkg::CMD_POP_CHECK;
            state_in = status.left_in ? S_POP_LEFT : S_DONE;
         end
         S_POP_LEFT: begin
            cmd      = bhpq_pkg::CMD_POP_LEFT;
            state_in = S_POP_DECIDE;
         end
         S_POP_DECIDE: begin
            cmd      = bhpq_pkg::CMD_POP_DECIDE;
            state_in = status.settle ? S_DONE : S_POP_CHECK;
         end
         S_DONE: begin
            if (out_free) begin
               cmd          = bhpq_pkg::CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/binary_heap_priority_queue_core.sv]
// Top level of the binary heap priority queue: stream ports, controller and datapath.
// Depends on bhpq_pkg, bhpq_ctrl, bhpq_datapath and bhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

// A priority queue of key and tag entries kept as a binary heap in one
// simple dual-port RAM. Each request beat is a push (tuser 0) or a pop (tuser 1),
// and each one yields exactly one response beat with the popped entry, the new
// front entry, the entry count and a status (0 ok, 1 push dropped because the
// store was full, 2 pop of an empty store). With csr_wr_data low the smallest
// key is served first, with it high the largest; equal keys leave in no
// guaranteed order. The register is written with csr_wr_en and should change
// only while no request is in flight; stored entries are not reordered by a mode
// change. The block works on one request at a time. The time a request takes
// is set by the single RAM read port, which serves one parent on each push
// level and the two children on each pop level, with a registered read before
// every compare. The block is ready for the next request once the response is
// loaded; the response register holds its beat until taken, while the next
// request already proceeds. No clearing pass is needed after reset.

module binary_heap_priority_queue_core #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEFAULT,
   parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEFAULT,
   localparam int CntW    = $clog2(CAPACITY + 1),
   localparam int ReqW    = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
   localparam int RspW    = ((2 * KEY_BITS + 2 * TAG_BITS + CntW + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [ReqW-1:0]                  req_tdata,  // key, tag
   input  wire logic                             req_tuser,  // action
   // Response channel.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [RspW-1:0]                  rsp_tdata,
   // rsp_tdata fields: popped_key, popped_tag, front_key, front_tag, entry_count
   output logic      [bhpq_pkg::STATUS_BITS-1:0] rsp_tuser,  // status
   // Mode register.
   input  wire logic                             csr_wr_en,
   input  wire logic                             csr_wr_data  // order_mode
);

   bhpq_pkg::cmd_type       cmd;
   bhpq_pkg::dp_status_type dp_status;

   logic [KEY_BITS-1:0] popped_key;
   logic [TAG_BITS-1:0] popped_tag;
   logic [KEY_BITS-1:0] front_key;
   logic [TAG_BITS-1:0] front_tag;
   logic [CntW-1:0]     entry_count;

   bhpq_ctrl u_bhpq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_action(req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   bhpq_datapath #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS),
      .TAG_BITS(TAG_BITS)
   ) u_bhpq_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (dp_status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .in_key       (req_tdata[KEY_BITS-1:0]),
      .in_tag       (req_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]),
      .popped_key   (popped_key),
      .popped_tag   (popped_tag),
      .front_key    (front_key),
      .front_tag    (front_tag),
      .entry_count  (entry_count),
      .result_status(rsp_tuser)
   );

   // Fields packed from the lowest bit up, padded with zeros to whole bytes.
   assign rsp_tdata = RspW'({entry_count, front_tag, front_key, popped_tag, popped_key});

endmodule

`default_nettype wire

[design/bhpq_checker.sv]
// Port-level checker of the binary heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue_core.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_checker #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEFAULT,
   parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEFAULT,
   localparam int CntW    = $clog2(CAPACITY + 1),
   localparam int EntW    = KEY_BITS + TAG_BITS,
   localparam int RspW    = ((2 * KEY_BITS + 2 * TAG_BITS + CntW + 7) / 8) * 8
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [RspW-1:0]                  rsp_tdata,
   input wire logic [bhpq_pkg::STATUS_BITS-1:0] rsp_tuser
);

   logic [EntW-1:0] popped;
   logic [EntW-1:0] front;
   logic [CntW-1:0] count;

   assign popped = rsp_tdata[EntW-1:0];
   assign front  = rsp_tdata[2*EntW-1:EntW];
   assign count  = rsp_tdata[2*EntW+CntW-1:2*EntW];

   // A waiting response beat holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= CntW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bhpq_pkg::STATUS_FULL |-> count == CntW'(CAPACITY))
      else $error("push dropped while store not full");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bhpq_pkg::STATUS_EMPTY |-> count == '0 && popped == '0)
      else $error("empty pop reported entries");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && count == '0 |-> front == '0)
      else $error("front entry shown on an empty store");

endmodule

bind binary_heap_priority_queue_core bhpq_checker #(
   .CAPACITY(CAPACITY),
   .KEY_BITS(KEY_BITS),
   .TAG_BITS(TAG_BITS)
) u_bhpq_checker (.*);

`default_nettype wire
